// File: rtl/core/ticvp_pkg.sv
// Package for the table inverse-CDF value perturber.
// Holds command codes, register indexes, the controller state type and
// the controller/datapath command and status structs. No dependencies.
package ticvp_pkg;

    // Input word command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_ACCUM_N  = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    // Field widths fixed by the interface
    localparam int VALUE_W  = 8;
    localparam int RESULT_W = 9;
    localparam int Q16_W    = 16;
    localparam int ROW_W    = 7;
    localparam int COL_W    = 4;
    localparam int CFG_W    = 7;

    // Reset values of the configuration registers
    localparam logic [6:0] ACCUM_N_RST  = 7'd0;
    localparam logic [3:0] NUM_COLS_RST = 4'd15;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_wr;   // write one table entry from the input word
        logic start;     // capture a sample word
        logic scan;      // scan the selected row
        logic deliver;   // move the result into the output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic direct;    // sample needs no scan (row error or no columns)
        logic scan_done; // scan has picked a column this cycle
    } dp_status_t;

endpackage

// File: rtl/core/ticvp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No dependencies.
module ticvp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ticvp_ctrl.sv
// Controller for the value perturber: input handshake, scan sequencing and
// output register valid. Depends on ticvp_pkg.
module ticvp_ctrl
    import ticvp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       in_cmd,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  ctrl
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        ctrl         = '0;
        ctrl.load_wr = accept && (in_cmd == CMD_LOAD);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_cmd == CMD_SAMPLE))
                begin
                    ctrl.start = 1'b1;
                    state_next = status.direct ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ctrl.deliver = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on delivery, cleared when the word is taken
    always_comb
    begin
        if (ctrl.deliver)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/ticvp_datapath.sv
// Datapath for the value perturber: configuration registers, probability
// table, row index, column scan and result registers.
// Depends on ticvp_pkg and ticvp_ram.
module ticvp_datapath
    import ticvp_pkg::*;
#(
    parameter int TABLE_ROWS = 128,
    parameter int TABLE_COLS = 16,
    parameter int PROB_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_cmd_t                  ctrl,
    output dp_status_t                 status,
    input  logic                       cfg_valid,
    input  logic                       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic [Q16_W-1:0]           ref_point,
    input  logic [ROW_W-1:0]           row,
    input  logic [COL_W-1:0]           col,
    input  logic [Q16_W-1:0]           prob,
    output logic signed [RESULT_W-1:0] result_value,
    output logic [COL_W-1:0]           chosen_col,
    output logic                       range_error
);

    localparam int RW    = $clog2(TABLE_ROWS);
    localparam int CW    = (TABLE_COLS > 1) ? $clog2(TABLE_COLS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = TABLE_ROWS * (2 ** CW);
    localparam int SH_L  = (PROB_BITS >= Q16_W) ? PROB_BITS - Q16_W : 0;
    localparam int SH_R  = (PROB_BITS < Q16_W) ? Q16_W - PROB_BITS : 0;

    // Configuration registers
    logic [6:0] accum_n_reg;
    logic [3:0] num_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_n_reg  <= ACCUM_N_RST;
            num_cols_reg <= NUM_COLS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ACCUM_N:  accum_n_reg  <= cfg_data[6:0];
                CFG_NUM_COLS: num_cols_reg <= cfg_data[3:0];
                default:      accum_n_reg  <= accum_n_reg;
            endcase
        end
    end

    // Q0.16 to table format
    logic [PROB_BITS-1:0] prob_al;
    logic [PROB_BITS-1:0] ref_al;

    assign prob_al = PROB_BITS'((32'(prob) << SH_L) >> SH_R);
    assign ref_al  = PROB_BITS'((32'(ref_point) << SH_L) >> SH_R);

    // Row index: (value + accum_n) / 2, truncating toward zero
    logic [9:0] sum;
    logic       sum_neg;
    logic       row_err;
    logic [7:0] row_idx;
    logic [3:0] ncols_in;

    assign sum     = {{2{value[7]}}, value} + {3'b000, accum_n_reg};
    assign sum_neg = sum[9];
    assign row_idx = sum_neg ? 8'd0 : sum[8:1];
    // minus one halves to row zero; anything lower is out of range
    assign row_err = sum_neg ? (sum != 10'h3FF) : (32'(sum[8:1]) >= TABLE_ROWS);
    assign ncols_in = (32'(num_cols_reg) > TABLE_COLS) ? 4'(TABLE_COLS) : num_cols_reg;

    assign status.direct = row_err || (ncols_in == 4'd0);

    // Captured sample
    logic signed [VALUE_W-1:0] sval_reg;
    logic [PROB_BITS-1:0]      ref_reg;
    logic [RW-1:0]             row_reg;
    logic [3:0]                ncols_reg;
    logic [2:0]                window_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            sval_reg   <= value;
            ref_reg    <= ref_al;
            row_reg    <= RW'(row_idx);
            ncols_reg  <= ncols_in;
            window_reg <= 3'((ncols_in - 4'd1) >> 1);
        end
    end

    // Probability table
    logic              load_ok;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [PROB_BITS-1:0] rd_data;
    logic [3:0]        issue_col_reg, issue_col_next;

    assign load_ok = (32'(row) < TABLE_ROWS) && (32'(col) < TABLE_COLS);
    assign wr_addr = {RW'(row), CW'(col)};
    assign rd_addr = {row_reg, CW'(issue_col_reg)};

    ticvp_ram #(
        .WIDTH (PROB_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ctrl.load_wr && load_ok),
        .wr_addr (wr_addr),
        .wr_data (prob_al),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Column scan: one read issued per cycle, checked the cycle after
    logic       chk_valid_reg, chk_valid_next;
    logic [3:0] chk_col_reg;
    logic       issue;
    logic       hit;
    logic       last;
    logic       done;
    logic [3:0] pick;

    assign hit   = (rd_data != '0) && (rd_data > ref_reg);
    assign last  = (chk_col_reg == ncols_reg - 4'd1);
    assign done  = ctrl.scan && chk_valid_reg && (hit || last);
    assign issue = ctrl.scan && !done && (issue_col_reg < ncols_reg);
    assign pick  = hit ? chk_col_reg : ncols_reg - 4'd1;

    assign status.scan_done = done;

    always_comb
    begin
        issue_col_next = issue_col_reg;
        chk_valid_next = 1'b0;
        if (ctrl.start)
        begin
            issue_col_next = 4'd0;
        end
        else if (issue)
        begin
            issue_col_next = issue_col_reg + 4'd1;
            chk_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_col_reg <= 4'd0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            issue_col_reg <= issue_col_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            chk_col_reg <= issue_col_reg;
        end
    end

    // Result: value + 2 * (pick - window), wrapped to 9 bits
    logic [9:0]                res_sum;
    logic signed [RESULT_W-1:0] res_value_reg;
    logic [COL_W-1:0]          res_col_reg;
    logic                      res_err_reg;

    assign res_sum = {{2{sval_reg[7]}}, sval_reg} + {5'b00000, pick, 1'b0}
                   - {6'b000000, window_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            // pass-through for row error and zero columns
            res_value_reg <= {value[7], value};
            res_col_reg   <= 4'd0;
            res_err_reg   <= row_err;
        end
        else if (done)
        begin
            res_value_reg <= res_sum[8:0];
            res_col_reg   <= pick;
            res_err_reg   <= 1'b0;
        end
    end

    // Output register
    logic signed [RESULT_W-1:0] out_value_reg;
    logic [COL_W-1:0]           out_col_reg;
    logic                       out_err_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.deliver)
        begin
            out_value_reg <= res_value_reg;
            out_col_reg   <= res_col_reg;
            out_err_reg   <= res_err_reg;
        end
    end

    assign result_value = out_value_reg;
    assign chosen_col   = out_col_reg;
    assign range_error  = out_err_reg;

endmodule

// File: rtl/core/table_inverse_cdf_value_perturber.sv
// Table inverse-CDF value perturber, top level.
// Instantiates ticvp_ctrl and ticvp_datapath; depends on ticvp_pkg.
//
// Input channel (in_valid/in_stall): a load word (cmd = load) writes one
// probability into the row/col table entry without stalling the input, back
// to back with further loads. A sample word (cmd = sample) perturbs value
// by a column drawn from its table row against ref_point.
// Output channel (out_valid/out_stall): one word per sample, none per load.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write
// accum_n and num_cols only while no sample is in progress.
//
// A sample is first captured, then scanned with one table read per column
// (the single read port of the table sets this); the last read is checked
// once its registered read data returns, and the result is then loaded
// into the output register. At most num_cols columns are scanned. Row
// errors and zero columns skip the scan. in_stall is high from capture
// until the result enters the output register. The output register lets a
// new word be taken while a result waits; if the receiver stalls, the next
// result is held until the register frees.
// Reset clears the controller and sets accum_n = 0, num_cols = 15. The
// table is not cleared: every entry read must be loaded first.
module table_inverse_cdf_value_perturber
    import ticvp_pkg::*;
#(
    parameter int TABLE_ROWS = 128,
    parameter int TABLE_COLS = 16,
    parameter int PROB_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       cmd,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic [Q16_W-1:0]           ref_point,
    input  logic [ROW_W-1:0]           row,
    input  logic [COL_W-1:0]           col,
    input  logic [Q16_W-1:0]           prob,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [RESULT_W-1:0] result_value,
    output logic [COL_W-1:0]           chosen_col,
    output logic                       range_error,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    ticvp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_cmd    (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    ticvp_datapath #(
        .TABLE_ROWS (TABLE_ROWS),
        .TABLE_COLS (TABLE_COLS),
        .PROB_BITS  (PROB_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .value        (value),
        .ref_point    (ref_point),
        .row          (row),
        .col          (col),
        .prob         (prob),
        .result_value (result_value),
        .chosen_col   (chosen_col),
        .range_error  (range_error)
    );

endmodule

// File: rtl/core/ticvp_checker.sv
// Port-level checker for the value perturber, bound to the top level.
// Depends on ticvp_pkg.
module ticvp_checker
    import ticvp_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       cmd,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [RESULT_W-1:0] result_value,
    input logic [COL_W-1:0]           chosen_col,
    input logic                       range_error
);

    // A stalled result word stays valid and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value)
            && $stable(chosen_col) && $stable(range_error))
        else $error("result word dropped or changed while stalled");

    // A range error reports column zero
    a_err_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> chosen_col == 4'd0)
        else $error("range error with non-zero column");

    // At most 15 columns are in use, so column 15 is never picked
    a_col_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> chosen_col != 4'd15)
        else $error("chosen column beyond the columns in use");

    // A sample word holds off the next word
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_SAMPLE |=> in_stall)
        else $error("input taken during a sample");

    // A load word leaves the input open
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_LOAD |=> !in_stall)
        else $error("input stalled after a load");

endmodule

bind table_inverse_cdf_value_perturber ticvp_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .chosen_col   (chosen_col),
    .range_error  (range_error)
);
